// ----- design/oversampled_supply_and_temp_monitor_core_macros.svh -----
// Assertion macros shared by the monitor's RTL.
`ifndef OVERSAMPLED_SUPPLY_AND_TEMP_MONITOR_CORE_MACROS_SVH
`define OVERSAMPLED_SUPPLY_AND_TEMP_MONITOR_CORE_MACROS_SVH

// Same-cycle implication, disabled while in reset.
`define OSMON_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("osmon: implication check failed");

// Next-cycle implication, disabled while in reset.
`define OSMON_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("osmon: next-cycle check failed");

`endif

// ----- design/osmon_pkg.sv -----
// Shared widths, constants, register indexes and unit interface types.
package osmon_pkg;

  localparam int SAMPLE_W           = 12;
  localparam int SUM_W              = 20;
  localparam int MAX_OVERSAMPLE_LOG2 = 8;
  localparam int CNT_W              = MAX_OVERSAMPLE_LOG2 + 1;
  localparam int KLOG_W             = 4;
  localparam int OUT_W              = 16;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 12;

  localparam logic [CFG_IDX_W-1:0] CFG_OVERSAMPLE_LOG2 = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_VREF_CAL        = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TS_CAL1         = 2'd2;

  localparam logic [KLOG_W-1:0]   RST_OVERSAMPLE_LOG2 = 4'd4;
  localparam logic [SAMPLE_W-1:0] RST_VREF_CAL        = 12'd1530;
  localparam logic [SAMPLE_W-1:0] RST_TS_CAL1         = 12'd1760;

  localparam int VREF_MV   = 3300;
  localparam int MV_SCALE  = 1000;
  localparam int TS_SLOPE  = 5336;
  localparam int TS_OFFSET = 30;
  localparam int INT16_MAX = 32767;
  localparam int INT16_MIN = -32768;

  localparam int VNUM_W  = 24;
  localparam int DIV_W   = 36;
  localparam int DVSR_W  = SUM_W;
  localparam int MUL_A_W = SUM_W;
  localparam int MUL_B_W = 15;
  localparam int PROD_W  = MUL_A_W + MUL_B_W;
  localparam int MAG_W   = 24;
  localparam int TRES_W  = 26;

  localparam int DIV_CNT_W = $clog2(DIV_W + 1);
  localparam int MUL_CNT_W = $clog2(MUL_B_W + 1);

  typedef struct packed {
    logic              start;
    logic [DIV_W-1:0]  dividend;
    logic [DVSR_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic               start;
    logic [MUL_A_W-1:0] multiplicand;
    logic [MUL_B_W-1:0] multiplier;
  } mul_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } unit_sts_t;

endpackage

// ----- design/osmon_in_if.sv -----
// Sample pair channel: valid/ready handshake with both conversions.
interface osmon_in_if;
  logic                              valid;
  logic                              ready;
  logic [osmon_pkg::SAMPLE_W-1:0]    ref_sample;
  logic [osmon_pkg::SAMPLE_W-1:0]    temp_sample;

  modport source (output valid, output ref_sample, output temp_sample, input ready);
  modport sink   (input valid, input ref_sample, input temp_sample, output ready);
endinterface

// ----- design/osmon_out_if.sv -----
// Result channel: valid/ready handshake with supply and temperature.
interface osmon_out_if;
  logic                           valid;
  logic                           ready;
  logic [osmon_pkg::OUT_W-1:0]    supply_mv;
  logic [osmon_pkg::OUT_W-1:0]    temp_celsius;

  modport source (output valid, output supply_mv, output temp_celsius, input ready);
  modport sink   (input valid, input supply_mv, input temp_celsius, output ready);
endinterface

// ----- design/osmon_div_serial.sv -----
// Restoring divider that retires one quotient bit per cycle.
module osmon_div_serial (
  input  logic                          clk,
  input  logic                          rst_n,
  input  osmon_pkg::div_req_t           req,
  output osmon_pkg::unit_sts_t          sts,
  output logic [osmon_pkg::DIV_W-1:0]   quo
);

  logic [osmon_pkg::DVSR_W-1:0]    rem_r, rem_nxt;
  logic [osmon_pkg::DVSR_W-1:0]    dvsr_r, dvsr_nxt;
  logic [osmon_pkg::DIV_W-1:0]     quo_r, quo_nxt;
  logic [osmon_pkg::DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic                            busy_r, busy_nxt;
  logic                            done_r, done_nxt;
  logic [osmon_pkg::DVSR_W:0]      shifted;
  logic [osmon_pkg::DVSR_W:0]      diff;
  logic                            fits;

  assign shifted = {rem_r, quo_r[osmon_pkg::DIV_W-1]};
  assign diff    = shifted - {1'b0, dvsr_r};
  assign fits    = shifted >= {1'b0, dvsr_r};

  always_comb begin
    rem_nxt  = rem_r;
    dvsr_nxt = dvsr_r;
    quo_nxt  = quo_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (req.start) begin
      rem_nxt  = '0;
      dvsr_nxt = req.divisor;
      quo_nxt  = req.dividend;
      cnt_nxt  = osmon_pkg::DIV_CNT_W'(osmon_pkg::DIV_W);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      rem_nxt = fits ? diff[osmon_pkg::DVSR_W-1:0] : shifted[osmon_pkg::DVSR_W-1:0];
      quo_nxt = {quo_r[osmon_pkg::DIV_W-2:0], fits};
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == osmon_pkg::DIV_CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    rem_r  <= rem_nxt;
    dvsr_r <= dvsr_nxt;
    quo_r  <= quo_nxt;
    if (!rst_n) begin
      cnt_r  <= '0;
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  assign sts.busy = busy_r;
  assign sts.done = done_r;
  assign quo      = quo_r;

endmodule

// ----- design/osmon_mul_serial.sv -----
// Shift-add multiplier that consumes one multiplier bit per cycle.
module osmon_mul_serial (
  input  logic                           clk,
  input  logic                           rst_n,
  input  osmon_pkg::mul_req_t            req,
  output osmon_pkg::unit_sts_t           sts,
  output logic [osmon_pkg::PROD_W-1:0]   prod
);

  logic [osmon_pkg::MUL_A_W-1:0]   mcand_r, mcand_nxt;
  logic [osmon_pkg::MUL_B_W-1:0]   mplier_r, mplier_nxt;
  logic [osmon_pkg::PROD_W:0]      acc_r, acc_nxt;
  logic [osmon_pkg::MUL_CNT_W-1:0] cnt_r, cnt_nxt;
  logic                            busy_r, busy_nxt;
  logic                            done_r, done_nxt;
  logic [osmon_pkg::MUL_A_W:0]     part_sum;

  assign part_sum = acc_r[osmon_pkg::PROD_W:osmon_pkg::MUL_B_W]
                  + (mplier_r[0] ? {1'b0, mcand_r} : '0);

  always_comb begin
    mcand_nxt  = mcand_r;
    mplier_nxt = mplier_r;
    acc_nxt    = acc_r;
    cnt_nxt    = cnt_r;
    busy_nxt   = busy_r;
    done_nxt   = 1'b0;
    if (req.start) begin
      mcand_nxt  = req.multiplicand;
      mplier_nxt = req.multiplier;
      acc_nxt    = '0;
      cnt_nxt    = osmon_pkg::MUL_CNT_W'(osmon_pkg::MUL_B_W);
      busy_nxt   = 1'b1;
    end else if (busy_r) begin
      acc_nxt    = {1'b0, part_sum, acc_r[osmon_pkg::MUL_B_W-1:1]};
      mplier_nxt = mplier_r >> 1;
      cnt_nxt    = cnt_r - 1'b1;
      if (cnt_r == osmon_pkg::MUL_CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    mcand_r  <= mcand_nxt;
    mplier_r <= mplier_nxt;
    acc_r    <= acc_nxt;
    if (!rst_n) begin
      cnt_r  <= '0;
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  assign sts.busy = busy_r;
  assign sts.done = done_r;
  assign prod     = acc_r[osmon_pkg::PROD_W-1:0];

endmodule

// ----- design/oversampled_supply_and_temp_monitor_core.sv -----
// Oversampled supply and temperature monitor: accumulation, sequencing, result register.
//
// Usage:
// - in_if carries one pair of 12-bit conversions (reference, temperature sensor)
//   per transaction. Each channel is summed over 2^min(oversample_log2, 8) pairs.
// - A pair that does not close the window is summed and taken without leaving idle.
// - The pair that closes the window starts a serial computation: one 36-step
//   divide for the supply (skipped when the reference average is zero), a
//   15-step multiply on a serial multiplier, then two more 36-step divides for
//   the temperature; the divides share one bit-serial divider. in_if.ready
//   stays low until the result register loads.
// - out_if delivers one transaction per window from an output register. A new
//   window may be collected while that result waits; if it is still not taken
//   when the next result is ready, the sequencer holds until it is.
// - cfg_we/cfg_idx/cfg_wdata write oversample_log2 (0), vref_cal (1) and
//   ts_cal1 (2); other indexes are dropped. Write only while idle.
// - rst_n (synchronous, active low) clears the sums, the pair count and the
//   result valid, and restores the calibration defaults.
`include "oversampled_supply_and_temp_monitor_core_macros.svh"

module oversampled_supply_and_temp_monitor_core (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_we,
  input  logic [osmon_pkg::CFG_IDX_W-1:0]    cfg_idx,
  input  logic [osmon_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  osmon_in_if.sink                           in_if,
  osmon_out_if.source                        out_if
);

  localparam int ST_W = 4;
  localparam logic [ST_W-1:0] S_IDLE      = 4'd0;
  localparam logic [ST_W-1:0] S_VCC       = 4'd1;
  localparam logic [ST_W-1:0] S_VCC_WAIT  = 4'd2;
  localparam logic [ST_W-1:0] S_MUL       = 4'd3;
  localparam logic [ST_W-1:0] S_MUL_WAIT  = 4'd4;
  localparam logic [ST_W-1:0] S_DIV2_WAIT = 4'd5;
  localparam logic [ST_W-1:0] S_SCALE     = 4'd6;
  localparam logic [ST_W-1:0] S_DIV3_WAIT = 4'd7;
  localparam logic [ST_W-1:0] S_FINISH    = 4'd8;

  logic [ST_W-1:0]                    state_r, state_nxt;
  logic [osmon_pkg::KLOG_W-1:0]       klog_r, klog_nxt;
  logic [osmon_pkg::SAMPLE_W-1:0]     vref_cal_r, vref_cal_nxt;
  logic [osmon_pkg::SAMPLE_W-1:0]     ts_cal1_r, ts_cal1_nxt;
  logic [osmon_pkg::SUM_W-1:0]        ref_sum_r, ref_sum_nxt;
  logic [osmon_pkg::SUM_W-1:0]        temp_sum_r, temp_sum_nxt;
  logic [osmon_pkg::CNT_W-1:0]        pair_count_r, pair_count_nxt;
  logic [osmon_pkg::SUM_W-1:0]        avg_ref_r, avg_ref_nxt;
  logic [osmon_pkg::SUM_W-1:0]        avg_temp_r, avg_temp_nxt;
  logic [osmon_pkg::MUL_B_W-1:0]      vcc_r, vcc_nxt;
  logic [osmon_pkg::MAG_W-1:0]        mag_r, mag_nxt;
  logic                               neg_r, neg_nxt;
  logic [osmon_pkg::OUT_W-1:0]        temp_r, temp_nxt;
  logic                               out_valid_r, out_valid_nxt;
  logic [osmon_pkg::OUT_W-1:0]        out_supply_r, out_supply_nxt;
  logic [osmon_pkg::OUT_W-1:0]        out_temp_r, out_temp_nxt;

  logic [osmon_pkg::KLOG_W-1:0]       klog_eff;
  logic [osmon_pkg::CNT_W-1:0]        window_len;
  logic [osmon_pkg::CNT_W-1:0]        count_inc;
  logic [osmon_pkg::SUM_W-1:0]        ref_sum_add;
  logic [osmon_pkg::SUM_W-1:0]        temp_sum_add;
  logic                               in_take;
  logic                               window_end;
  logic [osmon_pkg::VNUM_W-1:0]       vcc_num;
  logic [osmon_pkg::MAG_W-1:0]        q_mag;
  logic [osmon_pkg::MAG_W-1:0]        ts_ext;
  logic signed [osmon_pkg::TRES_W-1:0] q3_s;
  logic signed [osmon_pkg::TRES_W-1:0] tres;
  logic                               out_free;

  osmon_pkg::div_req_t                div_req;
  osmon_pkg::unit_sts_t               div_sts;
  logic [osmon_pkg::DIV_W-1:0]        div_quo;
  osmon_pkg::mul_req_t                mul_req;
  osmon_pkg::unit_sts_t               mul_sts;
  logic [osmon_pkg::PROD_W-1:0]       mul_prod;

  osmon_div_serial u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .sts   (div_sts),
    .quo   (div_quo)
  );

  osmon_mul_serial u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (mul_req),
    .sts   (mul_sts),
    .prod  (mul_prod)
  );

  assign klog_eff = (klog_r > osmon_pkg::KLOG_W'(osmon_pkg::MAX_OVERSAMPLE_LOG2))
                  ? osmon_pkg::KLOG_W'(osmon_pkg::MAX_OVERSAMPLE_LOG2) : klog_r;
  assign window_len   = osmon_pkg::CNT_W'(1) << klog_eff;
  assign count_inc    = pair_count_r + 1'b1;
  assign ref_sum_add  = ref_sum_r + osmon_pkg::SUM_W'(in_if.ref_sample);
  assign temp_sum_add = temp_sum_r + osmon_pkg::SUM_W'(in_if.temp_sample);
  assign in_take      = in_if.valid && (state_r == S_IDLE);
  assign window_end   = count_inc >= window_len;
  assign vcc_num      = osmon_pkg::VNUM_W'(vref_cal_r) * osmon_pkg::VNUM_W'(osmon_pkg::VREF_MV);
  assign q_mag        = div_quo[osmon_pkg::MAG_W-1:0];
  assign ts_ext       = osmon_pkg::MAG_W'(ts_cal1_r);
  assign q3_s         = signed'(osmon_pkg::TRES_W'(q_mag));
  assign tres         = neg_r ? signed'(osmon_pkg::TRES_W'(osmon_pkg::TS_OFFSET)) - q3_s
                              : signed'(osmon_pkg::TRES_W'(osmon_pkg::TS_OFFSET)) + q3_s;
  assign out_free     = !out_valid_r || out_if.ready;

  always_comb begin
    div_req.start    = 1'b0;
    div_req.dividend = osmon_pkg::DIV_W'(vcc_num);
    div_req.divisor  = avg_ref_r;
    mul_req.start        = 1'b0;
    mul_req.multiplicand = avg_temp_r;
    mul_req.multiplier   = vcc_r;
    unique case (state_r)
      S_VCC: begin
        div_req.start = (avg_ref_r != '0);
      end
      S_MUL: begin
        mul_req.start = 1'b1;
      end
      S_MUL_WAIT: begin
        div_req.start    = mul_sts.done;
        div_req.dividend = osmon_pkg::DIV_W'(mul_prod);
        div_req.divisor  = osmon_pkg::DVSR_W'(osmon_pkg::VREF_MV);
      end
      S_SCALE: begin
        div_req.start    = 1'b1;
        div_req.dividend = osmon_pkg::DIV_W'(mag_r) * osmon_pkg::DIV_W'(osmon_pkg::MV_SCALE);
        div_req.divisor  = osmon_pkg::DVSR_W'(osmon_pkg::TS_SLOPE);
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    state_nxt      = state_r;
    klog_nxt       = klog_r;
    vref_cal_nxt   = vref_cal_r;
    ts_cal1_nxt    = ts_cal1_r;
    ref_sum_nxt    = ref_sum_r;
    temp_sum_nxt   = temp_sum_r;
    pair_count_nxt = pair_count_r;
    avg_ref_nxt    = avg_ref_r;
    avg_temp_nxt   = avg_temp_r;
    vcc_nxt        = vcc_r;
    mag_nxt        = mag_r;
    neg_nxt        = neg_r;
    temp_nxt       = temp_r;
    out_valid_nxt  = out_valid_r && !out_if.ready;
    out_supply_nxt = out_supply_r;
    out_temp_nxt   = out_temp_r;

    if (cfg_we) begin
      unique case (cfg_idx)
        osmon_pkg::CFG_OVERSAMPLE_LOG2: klog_nxt     = cfg_wdata[osmon_pkg::KLOG_W-1:0];
        osmon_pkg::CFG_VREF_CAL:        vref_cal_nxt = cfg_wdata;
        osmon_pkg::CFG_TS_CAL1:         ts_cal1_nxt  = cfg_wdata;
        default: begin
        end
      endcase
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_take) begin
          if (window_end) begin
            avg_ref_nxt    = ref_sum_add >> klog_eff;
            avg_temp_nxt   = temp_sum_add >> klog_eff;
            ref_sum_nxt    = '0;
            temp_sum_nxt   = '0;
            pair_count_nxt = '0;
            state_nxt      = S_VCC;
          end else begin
            ref_sum_nxt    = ref_sum_add;
            temp_sum_nxt   = temp_sum_add;
            pair_count_nxt = count_inc;
          end
        end
      end
      S_VCC: begin
        if (avg_ref_r == '0) begin
          vcc_nxt   = osmon_pkg::MUL_B_W'(osmon_pkg::INT16_MAX);
          state_nxt = S_MUL;
        end else begin
          state_nxt = S_VCC_WAIT;
        end
      end
      S_VCC_WAIT: begin
        if (div_sts.done) begin
          vcc_nxt   = (div_quo > osmon_pkg::DIV_W'(osmon_pkg::INT16_MAX))
                    ? osmon_pkg::MUL_B_W'(osmon_pkg::INT16_MAX)
                    : div_quo[osmon_pkg::MUL_B_W-1:0];
          state_nxt = S_MUL;
        end
      end
      S_MUL: begin
        state_nxt = S_MUL_WAIT;
      end
      S_MUL_WAIT: begin
        if (mul_sts.done) begin
          state_nxt = S_DIV2_WAIT;
        end
      end
      S_DIV2_WAIT: begin
        if (div_sts.done) begin
          neg_nxt   = q_mag > ts_ext;
          mag_nxt   = (q_mag > ts_ext) ? q_mag - ts_ext : ts_ext - q_mag;
          state_nxt = S_SCALE;
        end
      end
      S_SCALE: begin
        state_nxt = S_DIV3_WAIT;
      end
      S_DIV3_WAIT: begin
        if (div_sts.done) begin
          if (tres > signed'(osmon_pkg::TRES_W'(osmon_pkg::INT16_MAX))) begin
            temp_nxt = osmon_pkg::OUT_W'(osmon_pkg::INT16_MAX);
          end else if (tres < signed'(osmon_pkg::TRES_W'(osmon_pkg::INT16_MIN))) begin
            temp_nxt = osmon_pkg::OUT_W'(osmon_pkg::INT16_MIN);
          end else begin
            temp_nxt = tres[osmon_pkg::OUT_W-1:0];
          end
          state_nxt = S_FINISH;
        end
      end
      S_FINISH: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_supply_nxt = {1'b0, vcc_r};
          out_temp_nxt   = temp_r;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    avg_ref_r    <= avg_ref_nxt;
    avg_temp_r   <= avg_temp_nxt;
    vcc_r        <= vcc_nxt;
    mag_r        <= mag_nxt;
    neg_r        <= neg_nxt;
    temp_r       <= temp_nxt;
    out_supply_r <= out_supply_nxt;
    out_temp_r   <= out_temp_nxt;
    if (!rst_n) begin
      state_r      <= S_IDLE;
      klog_r       <= osmon_pkg::RST_OVERSAMPLE_LOG2;
      vref_cal_r   <= osmon_pkg::RST_VREF_CAL;
      ts_cal1_r    <= osmon_pkg::RST_TS_CAL1;
      ref_sum_r    <= '0;
      temp_sum_r   <= '0;
      pair_count_r <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      klog_r       <= klog_nxt;
      vref_cal_r   <= vref_cal_nxt;
      ts_cal1_r    <= ts_cal1_nxt;
      ref_sum_r    <= ref_sum_nxt;
      temp_sum_r   <= temp_sum_nxt;
      pair_count_r <= pair_count_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  assign in_if.ready         = (state_r == S_IDLE);
  assign out_if.valid        = out_valid_r;
  assign out_if.supply_mv    = out_supply_r;
  assign out_if.temp_celsius = out_temp_r;

  `OSMON_ASSERT_IMPL(a_idle_units_quiet, clk, rst_n, in_if.ready, !div_sts.busy && !mul_sts.busy)
  `OSMON_ASSERT_IMPL(a_count_in_window, clk, rst_n, 1'b1, !pair_count_r[osmon_pkg::CNT_W-1])
  `OSMON_ASSERT_IMPL(a_div_start_free, clk, rst_n, div_req.start, !div_sts.busy && !mul_sts.busy)
  `OSMON_ASSERT_NEXT(a_div_done_pulse, clk, rst_n, div_sts.done, !div_sts.done)
  `OSMON_ASSERT_IMPL(a_result_from_finish, clk, rst_n, $rose(out_valid_r), $past(state_r) == S_FINISH)

endmodule
